// File: rtl/cct_pkg.sv
package cct_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W     = 16;
   localparam int PTS_W       = 9;
   localparam int GATE_W      = 31;
   localparam int DIV_STEPS   = GATE_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_IDX_W-1:0] REG_COMP_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_READY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_IN_USE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GATE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd5;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   localparam logic [1:0] ST_NORMAL = 2'd0;
   localparam logic [1:0] ST_OFF    = 2'd1;
   localparam logic [1:0] ST_GATED  = 2'd2;
   localparam logic [1:0] ST_CLAMP  = 2'd3;

   typedef struct packed {
      logic       lookup;
      logic       negative;
      logic [1:0] status;
   } div_tag_type;

endpackage

// File: rtl/cct_ram.sv
module cct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/cct_div.sv
module cct_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [2*cct_pkg::GATE_W-1:0]    in_dividend,
   input  logic [cct_pkg::GATE_W-1:0]      in_divisor,
   input  cct_pkg::div_tag_type            in_tag,
   output logic                            out_valid,
   output logic [cct_pkg::GATE_W-1:0]      out_quotient,
   output cct_pkg::div_tag_type            out_tag
);

   localparam int W = cct_pkg::GATE_W;
   localparam int N = cct_pkg::DIV_STEPS;

   logic [W-1:0]               rem_ff [N];
   logic [W-1:0]               lq_ff  [N];
   cct_pkg::div_tag_type       tag_ff [N];
   logic [N-1:0]               v_ff;
   logic [W-1:0]               rem_in [N];
   logic [W-1:0]               lq_in  [N];

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_step
         logic [W-1:0] rem_src;
         logic [W-1:0] lq_src;
         logic [W:0]   trial;
         logic [W:0]   diff;
         logic         ge;
         if (k == 0) begin : g_first
            assign rem_src = in_dividend[2*W-1:W];
            assign lq_src  = in_dividend[W-1:0];
         end else begin : g_next
            assign rem_src = rem_ff[k-1];
            assign lq_src  = lq_ff[k-1];
         end
         always_comb begin
            trial     = {rem_src, lq_src[W-1]};
            diff      = trial - {1'b0, in_divisor};
            ge        = (trial >= {1'b0, in_divisor});
            rem_in[k] = ge ? diff[W-1:0] : trial[W-1:0];
            lq_in[k]  = {lq_src[W-2:0], ge};
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            rem_ff[i] <= rem_in[i];
            lq_ff[i]  <= lq_in[i];
         end
         tag_ff[0] <= in_tag;
         for (int i = 1; i < N; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_valid    = v_ff[N-1];
   assign out_quotient = lq_ff[N-1];
   assign out_tag      = tag_ff[N-1];

endmodule

// File: rtl/cogging_comp_table_interp.sv
// Channel  Ports                                       Takes a word when
// req      req_valid, req_ready, req_func .. speed_ref req_valid and req_ready high
// rsp      rsp_valid, rsp_ready, rsp_comp_*            rsp_valid and rsp_ready high
// csr      csr_we, csr_index, csr_wdata                csr_we high
//
// One word enters per cycle while req_ready is high. A lookup result passes the input,
// table read, interpolation, gain and fade product stages and then the 31 fade divider
// stages, one quotient bit each, before it enters the output queue.
// Reset is synchronous and clears valid bits, the output queue and the registers;
// the table is undefined until written and is not cleared.
// A two-word output queue takes results while rsp_ready is low; when it is full the
// whole pipeline holds and req_ready is low.
module cogging_comp_table_interp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [7:0]                       req_entry_index,
   input  logic signed [15:0]               req_entry_value,
   input  logic [15:0]                      req_mech_angle,
   input  logic signed [31:0]               req_speed_ref,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_comp_current,
   output logic [1:0]                       rsp_comp_status,
   input  logic                             csr_we,
   input  logic [cct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cct_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = cct_pkg::ADDR_W;
   localparam int GW = cct_pkg::GATE_W;
   localparam int PW = cct_pkg::PTS_W;

   logic                comp_enable_ff;
   logic                table_ready_ff;
   logic [PW-1:0]       points_in_use_ff;
   logic [15:0]         gain_ff;
   logic [GW-1:0]       speed_gate_ff;
   logic [GW-1:0]       current_limit_ff;

   logic                en;
   logic [1:0]          q_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_enable_ff   <= 1'b0;
         table_ready_ff   <= 1'b0;
         points_in_use_ff <= '0;
         gain_ff          <= '0;
         speed_gate_ff    <= '0;
         current_limit_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cct_pkg::REG_COMP_ENABLE:   comp_enable_ff   <= csr_wdata[0];
            cct_pkg::REG_TABLE_READY:   table_ready_ff   <= csr_wdata[0];
            cct_pkg::REG_POINTS_IN_USE: points_in_use_ff <= csr_wdata[PW-1:0];
            cct_pkg::REG_GAIN:          gain_ff          <= csr_wdata[15:0];
            cct_pkg::REG_SPEED_GATE:    speed_gate_ff    <= csr_wdata[GW-1:0];
            cct_pkg::REG_CURRENT_LIMIT: current_limit_ff <= csr_wdata[GW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign en        = (q_count_ff != 2'd2);
   assign req_ready = en;

   // Input stage.
   logic                s0_v_ff;
   logic                s0_func_ff;
   logic [7:0]          s0_idx_ff;
   logic [15:0]         s0_val_ff;
   logic [15:0]         s0_angle_ff;
   logic [31:0]         s0_spd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_func_ff  <= req_func;
         s0_idx_ff   <= req_entry_index;
         s0_val_ff   <= req_entry_value;
         s0_angle_ff <= req_mech_angle;
         s0_spd_ff   <= req_speed_ref;
      end
   end

   // Table position, speed gate and table access.
   logic [PW-1:0]       pts;
   logic [PW+15:0]      pos;
   logic [PW-1:0]       i0;
   logic [PW-1:0]       i1_next;
   logic [PW-1:0]       i1;
   logic [31:0]         spd_abs;
   logic                gated;
   logic                inactive;
   logic [GW-1:0]       fade_mul;
   logic                tbl_we;
   logic [15:0]         rd0;
   logic [15:0]         rd1;

   always_comb begin
      pts = (points_in_use_ff > PW'(cct_pkg::TABLE_DEPTH)) ?
            PW'(cct_pkg::TABLE_DEPTH) : points_in_use_ff;
      pos      = (PW+16)'(s0_angle_ff) * (PW+16)'(pts);
      i0       = pos[PW+15:16];
      i1_next  = i0 + PW'(1);
      i1       = (i1_next >= pts) ? '0 : i1_next;
      spd_abs  = s0_spd_ff[31] ? (~s0_spd_ff + 32'd1) : s0_spd_ff;
      gated    = (speed_gate_ff != '0) && (spd_abs >= {1'b0, speed_gate_ff});
      inactive = !comp_enable_ff || !table_ready_ff || (pts < PW'(2));
      fade_mul = (speed_gate_ff == '0) ? GW'(1) : (speed_gate_ff - spd_abs[GW-1:0]);
      tbl_we   = en && s0_v_ff && (s0_func_ff == cct_pkg::FUNC_WRITE) &&
                 (int'(s0_idx_ff) < cct_pkg::TABLE_DEPTH);
   end

   cct_ram #(
      .WIDTH (cct_pkg::ENTRY_W),
      .DEPTH (cct_pkg::TABLE_DEPTH)
   ) u_ram_lo (
      .clock (clock),
      .we    (tbl_we),
      .waddr (AW'(s0_idx_ff)),
      .wdata (s0_val_ff),
      .re    (en),
      .raddr (AW'(i0)),
      .rdata (rd0)
   );

   cct_ram #(
      .WIDTH (cct_pkg::ENTRY_W),
      .DEPTH (cct_pkg::TABLE_DEPTH)
   ) u_ram_hi (
      .clock (clock),
      .we    (tbl_we),
      .waddr (AW'(s0_idx_ff)),
      .wdata (s0_val_ff),
      .re    (en),
      .raddr (AW'(i1)),
      .rdata (rd1)
   );

   logic                s1_v_ff;
   logic [15:0]         s1_frac_ff;
   logic [1:0]          s1_status_ff;
   logic [GW-1:0]       s1_mul_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= s0_v_ff && (s0_func_ff == cct_pkg::FUNC_LOOKUP);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_frac_ff   <= pos[15:0];
         s1_status_ff <= inactive ? cct_pkg::ST_OFF :
                         gated    ? cct_pkg::ST_GATED : cct_pkg::ST_NORMAL;
         s1_mul_ff    <= fade_mul;
      end
   end

   // Interpolation.
   logic signed [16:0]  diff;
   logic signed [33:0]  ip;
   logic signed [33:0]  num;
   logic                s2_v_ff;
   logic [31:0]         s2_num_ff;
   logic [1:0]          s2_status_ff;
   logic [GW-1:0]       s2_mul_ff;

   always_comb begin
      diff = $signed({rd1[15], rd1}) - $signed({rd0[15], rd0});
      ip   = diff * $signed({1'b0, s1_frac_ff});
      num  = $signed({{2{rd0[15]}}, rd0, 16'h0000}) + ip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_num_ff    <= num[31:0];
         s2_status_ff <= s1_status_ff;
         s2_mul_ff    <= s1_mul_ff;
      end
   end

   // Gain, on the magnitude so that the shift truncates toward zero.
   logic [31:0]         num_mag;
   logic [47:0]         scaled;
   logic                s3_v_ff;
   logic                s3_neg_ff;
   logic [GW-1:0]       s3_mag_ff;
   logic [1:0]          s3_status_ff;
   logic [GW-1:0]       s3_mul_ff;

   always_comb begin
      num_mag = s2_num_ff[31] ? (~s2_num_ff + 32'd1) : s2_num_ff;
      scaled  = 48'(num_mag) * 48'(gain_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_neg_ff    <= s2_num_ff[31];
         s3_mag_ff    <= scaled[GW+15:16];
         s3_status_ff <= s2_status_ff;
         s3_mul_ff    <= s2_mul_ff;
      end
   end

   // Fade product.
   logic                s4_v_ff;
   logic [2*GW-1:0]     s4_prod_ff;
   cct_pkg::div_tag_type s4_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_prod_ff         <= (2*GW)'(s3_mag_ff) * (2*GW)'(s3_mul_ff);
         s4_tag_ff.lookup   <= s3_v_ff;
         s4_tag_ff.negative <= s3_neg_ff;
         s4_tag_ff.status   <= s3_status_ff;
      end
   end

   logic [GW-1:0]        divisor;
   logic                 dv_valid;
   logic [GW-1:0]        dq;
   cct_pkg::div_tag_type dtag;

   assign divisor = (speed_gate_ff == '0) ? GW'(1) : speed_gate_ff;

   cct_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (s4_v_ff),
      .in_dividend  (s4_prod_ff),
      .in_divisor   (divisor),
      .in_tag       (s4_tag_ff),
      .out_valid    (dv_valid),
      .out_quotient (dq),
      .out_tag      (dtag)
   );

   // Sign, clamp and status.
   logic [31:0]         q_ext;
   logic [31:0]         lim_ext;
   logic [31:0]         res_cur;
   logic [1:0]          res_st;

   always_comb begin
      q_ext   = {1'b0, dq};
      lim_ext = {1'b0, current_limit_ff};
      if (dtag.status != cct_pkg::ST_NORMAL) begin
         res_cur = '0;
         res_st  = dtag.status;
      end else if (dq > current_limit_ff) begin
         res_cur = dtag.negative ? (~lim_ext + 32'd1) : lim_ext;
         res_st  = cct_pkg::ST_CLAMP;
      end else begin
         res_cur = dtag.negative ? (~q_ext + 32'd1) : q_ext;
         res_st  = cct_pkg::ST_NORMAL;
      end
   end

   // Output queue.
   logic                push;
   logic                pop;
   logic [31:0]         q0_cur_ff;
   logic [1:0]          q0_st_ff;
   logic [31:0]         q1_cur_ff;
   logic [1:0]          q1_st_ff;

   assign push = en && dv_valid && dtag.lookup;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= 2'd0;
      end else if (push && !pop) begin
         q_count_ff <= q_count_ff + 2'd1;
      end else if (pop && !push) begin
         q_count_ff <= q_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (push) begin
            q0_cur_ff <= res_cur;
            q0_st_ff  <= res_st;
         end else begin
            q0_cur_ff <= q1_cur_ff;
            q0_st_ff  <= q1_st_ff;
         end
      end else if (push) begin
         if (q_count_ff == 2'd0) begin
            q0_cur_ff <= res_cur;
            q0_st_ff  <= res_st;
         end else begin
            q1_cur_ff <= res_cur;
            q1_st_ff  <= res_st;
         end
      end
   end

   assign rsp_valid        = (q_count_ff != 2'd0);
   assign rsp_comp_current = q0_cur_ff;
   assign rsp_comp_status  = q0_st_ff;

endmodule

// File: rtl/cct_checker.sv
module cct_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_comp_current,
   input logic [1:0]         rsp_comp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_comp_current) && $stable(rsp_comp_status))
      else $error("Result word changed while stalled.");

   a_zero_when_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_comp_status == cct_pkg::ST_OFF ||
                    rsp_comp_status == cct_pkg::ST_GATED) |-> rsp_comp_current == 32'sd0)
      else $error("Disabled or gated result carries a nonzero current.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input stalled with no result waiting.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result offered right after reset.");

endmodule

bind cogging_comp_table_interp cct_checker u_cct_checker (.*);
